[sv/pwm_ook_code_transmitter_assert.svh]
// ----------------------------------------------------------------------------
// PWM OOK transmitter assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PWM_OOK_CODE_TRANSMITTER_ASSERT_SVH
`define PWM_OOK_CODE_TRANSMITTER_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define PWMOOK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PWMOOK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pwmook_pkg.sv]
// ----------------------------------------------------------------------------
// PWM OOK transmitter package
// Register layout, reset values, result type and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmook_pkg;

   localparam int CFG_W      = 20;
   localparam int CSR_IDX_W  = 3;

   localparam int HIGH_BITS_DEFAULT = 40;
   localparam int LOW_BITS_DEFAULT  = 50;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_GAP = 3'd7;

   // reset values
   localparam logic [CFG_W-1:0] SHORT_RST      = 20'd350;
   localparam logic [CFG_W-1:0] LONG_RST       = 20'd1050;
   localparam logic [CFG_W-1:0] SYNC_RST       = 20'd5000;
   localparam logic [CFG_W-1:0] GAP_RST        = 20'd1000;
   localparam logic [CFG_W-1:0] WARMUP_RST     = 20'd1000;
   localparam logic [CFG_W-1:0] TAIL_RST       = 20'd2000;
   localparam logic [CFG_W-1:0] REPEAT_GAP_RST = 20'd50000;

   typedef struct packed {
      logic             enable;
      logic [CFG_W-1:0] short_ticks;
      logic [CFG_W-1:0] long_ticks;
      logic [CFG_W-1:0] sync_ticks;
      logic [CFG_W-1:0] gap_ticks;
      logic [CFG_W-1:0] warmup_ticks;
      logic [CFG_W-1:0] tail_ticks;
      logic [CFG_W-1:0] repeat_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic radio_tx;
      logic busy_res;
      logic accepted;
      logic done_res;
   } rsp_type;

   // pulse lengths of zero count as one tick
   function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
      return (v == '0) ? CFG_W'(1) : v;
   endfunction

endpackage

`default_nettype wire

[sv/pwmook_rsp_buf.sv]
// ----------------------------------------------------------------------------
// PWM OOK result buffer
// Two-entry result queue; the input side stalls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pwm_ook_code_transmitter_assert.svh"

module pwmook_rsp_buf
   import pwmook_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PWMOOK_ASSERT(a_count_range, count_ff != 2'd3, "result buffer count out of range")
   `PWMOOK_ASSERT_NEXT(a_count_grow, push && !pop, count_ff == $past(count_ff) + 2'd1, "result buffer lost a push")

endmodule

`default_nettype wire

[sv/pwmook_core.sv]
// ----------------------------------------------------------------------------
// PWM OOK transmitter core
// Frame sequencer: phase, tick counter and code shifters, one request a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pwm_ook_code_transmitter_assert.svh"

module pwmook_core
   import pwmook_pkg::*;
#(
   parameter int HIGH_BITS = HIGH_BITS_DEFAULT,
   parameter int LOW_BITS  = LOW_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 in_accept,
   input  wire logic                 in_mode,
   input  wire logic [HIGH_BITS-1:0] in_code_high,
   input  wire logic [LOW_BITS-1:0]  in_code_low,
   input  wire logic [7:0]           in_repeat_count,
   output rsp_type                   res
);

   localparam int TOTAL = HIGH_BITS + LOW_BITS;
   localparam int BPW   = $clog2(TOTAL + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WARMUP,
      PH_SYNC,
      PH_GAP,
      PH_BITHI,
      PH_BITLO,
      PH_TAIL,
      PH_REPGAP
   } phase_type;

   phase_type            ph_ff, ph_in;
   logic [CFG_W-1:0]     cnt_ff, cnt_in;
   logic [BPW-1:0]       bpos_ff, bpos_in;
   logic [HIGH_BITS-1:0] hs_ff, hs_in, sh_ff, sh_in;
   logic [LOW_BITS-1:0]  ls_ff, ls_in, sl_ff, sl_in;
   logic [7:0]           rep_ff, rep_in;

   logic cur_bit, next_bit;
   logic acc, done;
   logic go_warm, go_tail, go_rg, end_rg, go_bithi;

   assign cur_bit = (bpos_ff < BPW'(HIGH_BITS)) ? hs_ff[HIGH_BITS-1] : ls_ff[LOW_BITS-1];

   always_comb begin
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      bpos_in  = bpos_ff;
      hs_in    = hs_ff;
      ls_in    = ls_ff;
      sh_in    = sh_ff;
      sl_in    = sl_ff;
      rep_in   = rep_ff;
      acc      = 1'b0;
      done     = 1'b0;
      go_warm  = 1'b0;
      go_tail  = 1'b0;
      go_rg    = 1'b0;
      end_rg   = 1'b0;
      go_bithi = 1'b0;
      next_bit = 1'b0;

      if (in_accept) begin
         if (in_mode) begin
            if (cfg.enable && ph_ff == PH_IDLE) begin
               acc    = 1'b1;
               sh_in  = in_code_high;
               sl_in  = in_code_low;
               rep_in = in_repeat_count;
               if (in_repeat_count != 8'd0) begin
                  hs_in   = in_code_high;
                  ls_in   = in_code_low;
                  bpos_in = '0;
                  go_warm = 1'b1;
               end
            end
         end else if (ph_ff != PH_IDLE) begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_in == '0) begin
               case (ph_ff)
                  PH_WARMUP: begin
                     ph_in  = PH_SYNC;
                     cnt_in = at_least_one(cfg.sync_ticks);
                  end
                  PH_SYNC: begin
                     ph_in  = PH_GAP;
                     cnt_in = at_least_one(cfg.gap_ticks);
                  end
                  PH_GAP: begin
                     go_bithi = 1'b1;
                  end
                  PH_BITHI: begin
                     ph_in  = PH_BITLO;
                     cnt_in = at_least_one(cur_bit ? cfg.short_ticks : cfg.long_ticks);
                  end
                  PH_BITLO: begin
                     // advance to the next code bit
                     if (bpos_ff < BPW'(HIGH_BITS)) begin
                        hs_in = hs_ff << 1;
                     end else begin
                        ls_in = ls_ff << 1;
                     end
                     bpos_in = bpos_ff + 1'b1;
                     if (bpos_in == BPW'(TOTAL)) begin
                        go_tail = 1'b1;
                     end else begin
                        go_bithi = 1'b1;
                     end
                  end
                  PH_TAIL:   go_rg  = 1'b1;
                  PH_REPGAP: end_rg = 1'b1;
                  default: ;
               endcase
            end
         end
      end

      // zero-length waits fall through within the same request
      if (go_tail) begin
         if (cfg.tail_ticks == '0) begin
            go_rg = 1'b1;
         end else begin
            ph_in  = PH_TAIL;
            cnt_in = cfg.tail_ticks;
         end
      end
      if (go_rg) begin
         if (cfg.repeat_gap_ticks == '0) begin
            end_rg = 1'b1;
         end else begin
            ph_in  = PH_REPGAP;
            cnt_in = cfg.repeat_gap_ticks;
         end
      end
      if (end_rg) begin
         rep_in = rep_ff - 8'd1;
         if (rep_in == 8'd0) begin
            done   = 1'b1;
            ph_in  = PH_IDLE;
            cnt_in = '0;
         end else begin
            hs_in   = sh_ff;
            ls_in   = sl_ff;
            bpos_in = '0;
            go_warm = 1'b1;
         end
      end
      if (go_warm) begin
         if (cfg.warmup_ticks == '0) begin
            ph_in  = PH_SYNC;
            cnt_in = at_least_one(cfg.sync_ticks);
         end else begin
            ph_in  = PH_WARMUP;
            cnt_in = cfg.warmup_ticks;
         end
      end
      if (go_bithi) begin
         next_bit = (bpos_in < BPW'(HIGH_BITS)) ? hs_in[HIGH_BITS-1] : ls_in[LOW_BITS-1];
         ph_in    = PH_BITHI;
         cnt_in   = at_least_one(next_bit ? cfg.long_ticks : cfg.short_ticks);
      end
   end

   always_comb begin
      res.line_level = (ph_in == PH_SYNC) || (ph_in == PH_BITHI);
      res.radio_tx   = (ph_in != PH_IDLE) && (ph_in != PH_REPGAP);
      res.busy_res   = (ph_in != PH_IDLE);
      res.accepted   = acc;
      res.done_res   = done;
   end

   always_ff @(posedge clock) begin
      hs_ff <= hs_in;
      ls_ff <= ls_in;
      sh_ff <= sh_in;
      sl_ff <= sl_in;
      if (reset) begin
         ph_ff   <= PH_IDLE;
         cnt_ff  <= '0;
         bpos_ff <= '0;
         rep_ff  <= 8'd0;
      end else begin
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         bpos_ff <= bpos_in;
         rep_ff  <= rep_in;
      end
   end

   `PWMOOK_ASSERT(a_busy_count, (ph_ff != PH_IDLE) |-> (cnt_ff != '0), "active phase with empty tick counter")
   `PWMOOK_ASSERT(a_bit_range, bpos_ff <= BPW'(TOTAL), "bit position past end of frame")
   `PWMOOK_ASSERT(a_done_idle, res.done_res |-> !res.busy_res, "done reported while still busy")
   `PWMOOK_ASSERT_NEXT(a_busy_start, in_accept && in_mode && (ph_ff != PH_IDLE), ph_ff == $past(ph_ff) && cnt_ff == $past(cnt_ff), "start while busy disturbed the frame")

endmodule

`default_nettype wire

[sv/pwm_ook_code_transmitter.sv]
// ----------------------------------------------------------------------------
// PWM OOK code transmitter
// Pulse-width on-off-keyed remote control encoder driven by 1 us ticks.
// ----------------------------------------------------------------------------
// Every request (a tick or a start command) gives one result, and
// requests may arrive on every cycle while req_stall is low. The sequencer
// updates its phase, tick counter and code shifters in a single pass at the
// accepting edge; the result enters a two-entry buffer and is offered from
// there in order. req_stall rises only while both buffer entries are
// full. Configuration writes take effect from the next phase.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_ook_code_transmitter
   import pwmook_pkg::*;
#(
   parameter int HIGH_BITS = HIGH_BITS_DEFAULT,
   parameter int LOW_BITS  = LOW_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_mode,
   input  wire logic [HIGH_BITS-1:0] req_code_high,
   input  wire logic [LOW_BITS-1:0]  req_code_low,
   input  wire logic [7:0]           req_repeat_count,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_line_level,
   output logic                      rsp_radio_tx,
   output logic                      rsp_busy_res,
   output logic                      rsp_accepted,
   output logic                      rsp_done_res,

   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   rsp_type res, rsp_data;
   logic    req_accept;
   logic    buf_full;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE:     cfg_in.enable           = csr_wdata[0];
            CSR_SHORT:      cfg_in.short_ticks      = csr_wdata;
            CSR_LONG:       cfg_in.long_ticks       = csr_wdata;
            CSR_SYNC:       cfg_in.sync_ticks       = csr_wdata;
            CSR_GAP:        cfg_in.gap_ticks        = csr_wdata;
            CSR_WARMUP:     cfg_in.warmup_ticks     = csr_wdata;
            CSR_TAIL:       cfg_in.tail_ticks       = csr_wdata;
            CSR_REPEAT_GAP: cfg_in.repeat_gap_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b0;
         cfg_ff.short_ticks      <= SHORT_RST;
         cfg_ff.long_ticks       <= LONG_RST;
         cfg_ff.sync_ticks       <= SYNC_RST;
         cfg_ff.gap_ticks        <= GAP_RST;
         cfg_ff.warmup_ticks     <= WARMUP_RST;
         cfg_ff.tail_ticks       <= TAIL_RST;
         cfg_ff.repeat_gap_ticks <= REPEAT_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwmook_core #(
      .HIGH_BITS (HIGH_BITS),
      .LOW_BITS  (LOW_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_accept       (req_accept),
      .in_mode         (req_mode),
      .in_code_high    (req_code_high),
      .in_code_low     (req_code_low),
      .in_repeat_count (req_repeat_count),
      .res             (res)
   );

   pwmook_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_line_level = rsp_data.line_level;
   assign rsp_radio_tx   = rsp_data.radio_tx;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_accepted   = rsp_data.accepted;
   assign rsp_done_res   = rsp_data.done_res;

endmodule

`default_nettype wire
